// ----- hdl/fwpa_pkg.sv -----
// shared codes, field widths and sequencer states of the word pool allocator
`timescale 1ns / 1ps
`default_nettype none
package fwpa_pkg;

  localparam int unsigned CfgW  = 11;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned ReqW  = 12;
  localparam int unsigned IdxW  = 10;
  localparam int unsigned StatW = 2;
  localparam int unsigned PctW  = 7;

  localparam logic [CfgW-1:0] CfgRst = 11'd1024;
  localparam logic [CfgW-1:0] MinPoolWords = 11'd3;
  localparam logic [PctW-1:0] PctScale = 7'd100;

  localparam logic [CmdW-1:0] CmdInit  = 2'd0;
  localparam logic [CmdW-1:0] CmdAlloc = 2'd1;
  localparam logic [CmdW-1:0] CmdFree  = 2'd2;
  localparam logic [CmdW-1:0] CmdUsage = 2'd3;

  localparam logic [StatW-1:0] StatOk    = 2'd0;
  localparam logic [StatW-1:0] StatNoFit = 2'd1;
  localparam logic [StatW-1:0] StatBad   = 2'd2;

  typedef enum logic [4:0] {
    StIdle,
    StInitHead,
    StInitEnd,
    StAlRd,
    StAlEv,
    StAlSplit,
    StFrRd,
    StFrEv,
    StFcRd,
    StFcEv,
    StMgChk,
    StMgEv,
    StUsRd,
    StUsEv,
    StUsMul,
    StUsDiv,
    StDone
  } state_e;

endpackage
`default_nettype wire

// ----- hdl/fwpa_div.sv -----
// restoring divider for the usage percentage, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module fwpa_div #(
  parameter int unsigned NUM_W = 24,
  parameter int unsigned DEN_W = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [NUM_W-1:0]            num_i,
  input  logic [DEN_W-1:0]            den_i,
  output logic                        done_o,
  output logic [fwpa_pkg::PctW-1:0]   quot_o
);

  localparam int unsigned XW = NUM_W + fwpa_pkg::PctW;
  localparam int unsigned CntW = $clog2(fwpa_pkg::PctW);

  logic                      run_q, run_d;
  logic                      done_q, done_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [XW-1:0]             rem_q, rem_d;
  logic [DEN_W-1:0]          den_q, den_d;
  logic [fwpa_pkg::PctW-1:0] quot_q, quot_d;
  logic [XW-1:0]             trial;

  assign trial = XW'(den_q) << cnt_q;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = CntW'(fwpa_pkg::PctW - 1);
      rem_d  = XW'(num_i);
      den_d  = den_i;
      quot_d = '0;
    end else if (run_q) begin
      if (rem_q >= trial) begin
        rem_d         = rem_q - trial;
        quot_d[cnt_q] = 1'b1;
      end
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

// ----- hdl/first_fit_word_pool_allocator.sv -----
// top level: header memory, command sequencer and chain walks of the pool allocator
`timescale 1ns / 1ps
`default_nettype none
// The pool headers live in one single-port-read, single-port-write memory of POOL_WORDS
// entries; allocate, free and usage walk the header chain through it, one header per cycle
// except in the merge steps of a free. An item is taken when start is high and busy is low;
// busy stays high until the result has been shown with done_o for one cycle, which cannot
// be held off. Init writes the start header and the end word. Allocate visits headers until
// the first free one that fits or the end word. Free walks the headers up to the freed block,
// then merges or advances step by step up to the end word. Usage walks every header, then
// runs the divide. Any command but init before the first init is answered with status 2.
// pool_size_words_i only takes effect at the next init; the header memory is not cleared at
// reset since nothing reads it before an init.
module first_fit_word_pool_allocator #(
  parameter int unsigned POOL_WORDS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [fwpa_pkg::CmdW-1:0]    command_i,
  input  logic [fwpa_pkg::ReqW-1:0]    request_bytes_i,
  input  logic [fwpa_pkg::IdxW-1:0]    block_index_i,
  input  logic                         cfg_we_i,
  input  logic [fwpa_pkg::CfgW-1:0]    pool_size_words_i,
  output logic                         done_o,
  output logic [fwpa_pkg::StatW-1:0]   status_o,
  output logic [fwpa_pkg::IdxW-1:0]    payload_index_o,
  output logic [fwpa_pkg::PctW-1:0]    usage_percent_o
);

  localparam int unsigned AW = $clog2(POOL_WORDS);
  localparam int unsigned HW = AW + 1;
  localparam int unsigned LW = AW + 1;
  localparam int unsigned XW = (AW > fwpa_pkg::IdxW) ? AW : fwpa_pkg::IdxW;
  localparam int unsigned NW = (LW > fwpa_pkg::CfgW) ? LW : fwpa_pkg::CfgW;
  localparam int unsigned SW = LW + fwpa_pkg::PctW;
  localparam int unsigned RstLast = ((POOL_WORDS < 1024) ? POOL_WORDS : 1024) - 1;

  fwpa_pkg::state_e state_q, state_d;

  logic [fwpa_pkg::CfgW-1:0]  size_q;
  logic [AW-1:0]              last_q, last_d;
  logic                       ready_q, ready_d;
  logic [AW-1:0]              h_q, h_d;
  logic [AW-1:0]              n_q, n_d;
  logic                       u_q, u_d;
  logic [fwpa_pkg::IdxW-1:0]  t_q, t_d;
  logic [NW-1:0]              need_q, need_d;
  logic [LW-1:0]              total_q, total_d;
  logic [LW-1:0]              busy_q, busy_d;
  logic [fwpa_pkg::StatW-1:0] status_q, status_d;
  logic [fwpa_pkg::IdxW-1:0]  pidx_q, pidx_d;
  logic [fwpa_pkg::PctW-1:0]  pct_q, pct_d;

  logic [HW-1:0] hdr_mem [POOL_WORDS];
  logic [HW-1:0] rd_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [HW-1:0] wr_data;
  logic          rd_used;
  logic [AW-1:0] rd_next;

  logic [NW-1:0] size_ext, clamp_w;
  logic [AW-1:0] last_w;
  logic          cmd_bad;
  logic [NW-1:0] diff;
  logic [LW-1:0] pay;
  logic          at_end;

  logic                      div_start, div_done;
  logic [SW-1:0]             div_num;
  logic [fwpa_pkg::PctW-1:0] div_quot;

  assign rd_used = rd_q[AW];
  assign rd_next = rd_q[AW-1:0];
  assign at_end  = (rd_next >= last_q);
  assign diff    = NW'(rd_next) - NW'(h_q);
  assign pay     = LW'(rd_next) - LW'(h_q) - LW'(1);
  assign div_num = SW'(busy_q) * SW'(fwpa_pkg::PctScale);

  // clamp the configured length between the minimum pool size and the storage
  always_comb begin
    size_ext = NW'(size_q);
    if (size_ext < NW'(fwpa_pkg::MinPoolWords)) begin
      clamp_w = NW'(fwpa_pkg::MinPoolWords);
    end else if (size_ext > NW'(POOL_WORDS)) begin
      clamp_w = NW'(POOL_WORDS);
    end else begin
      clamp_w = size_ext;
    end
    last_w = AW'(clamp_w - NW'(1));
  end

  always_comb begin
    cmd_bad = 1'b0;
    unique case (command_i)
      fwpa_pkg::CmdInit:  cmd_bad = 1'b0;
      fwpa_pkg::CmdAlloc: cmd_bad = !ready_q || (request_bytes_i == '0);
      fwpa_pkg::CmdFree:  cmd_bad = !ready_q || (block_index_i == '0);
      fwpa_pkg::CmdUsage: cmd_bad = !ready_q;
      default:            cmd_bad = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fwpa_pkg::StIdle: begin
        if (start) begin
          if (cmd_bad) begin
            state_d = fwpa_pkg::StDone;
          end else begin
            unique case (command_i)
              fwpa_pkg::CmdInit:  state_d = fwpa_pkg::StInitHead;
              fwpa_pkg::CmdAlloc: state_d = fwpa_pkg::StAlRd;
              fwpa_pkg::CmdFree: begin
                // block at word one has its header at word zero, no walk needed
                state_d = (block_index_i == fwpa_pkg::IdxW'(1)) ?
                          fwpa_pkg::StFcRd : fwpa_pkg::StFrRd;
              end
              fwpa_pkg::CmdUsage: state_d = fwpa_pkg::StUsRd;
              default:            state_d = fwpa_pkg::StDone;
            endcase
          end
        end
      end
      fwpa_pkg::StInitHead: state_d = fwpa_pkg::StInitEnd;
      fwpa_pkg::StInitEnd:  state_d = fwpa_pkg::StDone;
      fwpa_pkg::StAlRd:     state_d = fwpa_pkg::StAlEv;
      fwpa_pkg::StAlEv: begin
        if (!rd_used && diff > need_q) begin
          state_d = (diff == need_q + NW'(1)) ? fwpa_pkg::StDone : fwpa_pkg::StAlSplit;
        end else if (at_end) begin
          state_d = fwpa_pkg::StDone;
        end
      end
      fwpa_pkg::StAlSplit: state_d = fwpa_pkg::StDone;
      fwpa_pkg::StFrRd:    state_d = fwpa_pkg::StFrEv;
      fwpa_pkg::StFrEv: begin
        if (at_end) begin
          state_d = fwpa_pkg::StDone;
        end else if (XW'(rd_next) == XW'(t_q)) begin
          state_d = fwpa_pkg::StFcRd;
        end
      end
      fwpa_pkg::StFcRd:  state_d = fwpa_pkg::StFcEv;
      fwpa_pkg::StFcEv:  state_d = fwpa_pkg::StMgChk;
      fwpa_pkg::StMgChk: state_d = (n_q >= last_q) ? fwpa_pkg::StDone : fwpa_pkg::StMgEv;
      fwpa_pkg::StMgEv:  state_d = fwpa_pkg::StMgChk;
      fwpa_pkg::StUsRd:  state_d = fwpa_pkg::StUsEv;
      fwpa_pkg::StUsEv:  state_d = at_end ? fwpa_pkg::StUsMul : fwpa_pkg::StUsEv;
      fwpa_pkg::StUsMul: state_d = fwpa_pkg::StUsDiv;
      fwpa_pkg::StUsDiv: state_d = div_done ? fwpa_pkg::StDone : fwpa_pkg::StUsDiv;
      fwpa_pkg::StDone:  state_d = fwpa_pkg::StIdle;
      default:           state_d = fwpa_pkg::StIdle;
    endcase
  end

  // memory control and datapath
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    div_start = 1'b0;
    last_d    = last_q;
    ready_d   = ready_q;
    h_d       = h_q;
    n_d       = n_q;
    u_d       = u_q;
    t_d       = t_q;
    need_d    = need_q;
    total_d   = total_q;
    busy_d    = busy_q;
    status_d  = status_q;
    pidx_d    = pidx_q;
    pct_d     = pct_q;
    unique case (state_q)
      fwpa_pkg::StIdle: begin
        if (start) begin
          status_d = cmd_bad ? fwpa_pkg::StatBad : fwpa_pkg::StatOk;
          pidx_d   = '0;
          pct_d    = '0;
          h_d      = '0;
          total_d  = '0;
          busy_d   = '0;
          need_d   = NW'((13'(request_bytes_i) + 13'd3) >> 2);
          t_d      = block_index_i - fwpa_pkg::IdxW'(1);
          if (command_i == fwpa_pkg::CmdInit) begin
            last_d  = last_w;
            ready_d = 1'b1;
          end
        end
      end
      fwpa_pkg::StInitHead: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = {1'b0, last_q};
      end
      fwpa_pkg::StInitEnd: begin
        // end word points to itself and counts as used
        wr_en   = 1'b1;
        wr_addr = last_q;
        wr_data = {1'b1, last_q};
      end
      fwpa_pkg::StAlRd, fwpa_pkg::StFrRd, fwpa_pkg::StUsRd: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      fwpa_pkg::StAlEv: begin
        if (!rd_used && diff > need_q) begin
          pidx_d = fwpa_pkg::IdxW'(XW'(h_q) + XW'(1));
          wr_en  = 1'b1;
          if (diff == need_q + NW'(1)) begin
            // exact fit: take the block whole
            wr_addr = h_q;
            wr_data = {1'b1, rd_next};
          end else begin
            wr_addr = AW'(NW'(h_q) + NW'(1) + need_q);
            wr_data = {1'b0, rd_next};
            n_d     = AW'(NW'(h_q) + NW'(1) + need_q);
          end
        end else if (at_end) begin
          status_d = fwpa_pkg::StatNoFit;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_next;
          h_d     = rd_next;
        end
      end
      fwpa_pkg::StAlSplit: begin
        wr_en   = 1'b1;
        wr_addr = h_q;
        wr_data = {1'b1, n_q};
      end
      fwpa_pkg::StFrEv: begin
        if (at_end) begin
          status_d = fwpa_pkg::StatBad;
        end else if (XW'(rd_next) != XW'(t_q)) begin
          rd_en   = 1'b1;
          rd_addr = rd_next;
        end
      end
      fwpa_pkg::StFcRd: begin
        rd_en   = 1'b1;
        rd_addr = AW'(t_q);
        h_d     = AW'(t_q);
      end
      fwpa_pkg::StFcEv: begin
        wr_en   = 1'b1;
        wr_addr = h_q;
        wr_data = {1'b0, rd_next};
        u_d     = 1'b0;
        n_d     = rd_next;
      end
      fwpa_pkg::StMgChk: begin
        if (n_q < last_q) begin
          rd_en   = 1'b1;
          rd_addr = n_q;
        end
      end
      fwpa_pkg::StMgEv: begin
        if (!u_q && !rd_used) begin
          // absorb the following free block
          wr_en   = 1'b1;
          wr_addr = h_q;
          wr_data = {1'b0, rd_next};
          n_d     = rd_next;
        end else begin
          h_d = n_q;
          u_d = rd_used;
          n_d = rd_next;
        end
      end
      fwpa_pkg::StUsEv: begin
        total_d = total_q + pay;
        if (rd_used) begin
          busy_d = busy_q + pay;
        end
        if (!at_end) begin
          rd_en   = 1'b1;
          rd_addr = rd_next;
          h_d     = rd_next;
        end
      end
      fwpa_pkg::StUsMul: div_start = 1'b1;
      fwpa_pkg::StUsDiv: begin
        if (div_done) begin
          pct_d = (total_q == '0) ? '0 : div_quot;
        end
      end
      fwpa_pkg::StDone: begin
      end
      default: begin
      end
    endcase
  end

  fwpa_div #(
    .NUM_W(SW),
    .DEN_W(LW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (total_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hdr_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= hdr_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fwpa_pkg::StIdle;
      size_q  <= fwpa_pkg::CfgRst;
      last_q  <= AW'(RstLast);
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        size_q <= pool_size_words_i;
      end
      last_q  <= last_d;
      ready_q <= ready_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q      <= h_d;
    n_q      <= n_d;
    u_q      <= u_d;
    t_q      <= t_d;
    need_q   <= need_d;
    total_q  <= total_d;
    busy_q   <= busy_d;
    status_q <= status_d;
    pidx_q   <= pidx_d;
    pct_q    <= pct_d;
  end

  assign busy            = (state_q != fwpa_pkg::StIdle);
  assign done_o          = (state_q == fwpa_pkg::StDone);
  assign status_o        = status_q;
  assign payload_index_o = pidx_q;
  assign usage_percent_o = pct_q;

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// self-checking testbench of the first-fit word pool allocator
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned PoolMax = 1024;
  localparam int unsigned StallLimit = 40000;

  typedef struct packed {
    logic [fwpa_pkg::StatW-1:0] status;
    logic [fwpa_pkg::IdxW-1:0]  payload_index;
    logic [fwpa_pkg::PctW-1:0]  usage_percent;
  } pool_answer_t;

  class pool_scoreboard;
    int unsigned link_to[PoolMax];
    bit          in_use[PoolMax];
    int unsigned size_reg;
    int unsigned pool_len;
    bit          pool_built;
    pool_answer_t answers[$];
    int unsigned live_blocks[$];
    int unsigned errors;

    function new();
      size_reg = PoolMax;
      rebuild();
      pool_built = 1'b0;
      errors = 0;
    endfunction

    function void rebuild();
      int unsigned last;
      if (size_reg < fwpa_pkg::MinPoolWords) pool_len = fwpa_pkg::MinPoolWords;
      else if (size_reg > PoolMax) pool_len = PoolMax;
      else pool_len = size_reg;
      last = pool_len - 1;
      for (int i = 0; i < PoolMax; i++) begin
        link_to[i] = 0;
        in_use[i] = 1'b0;
      end
      link_to[0] = last;
      link_to[last] = last;
      in_use[last] = 1'b1;
      live_blocks.delete();
    endfunction

    function bit first_fit(int unsigned bytes, output int unsigned payload);
      int unsigned need, h, n, pay, last, guard;
      need = (bytes + 3) / 4;
      last = pool_len - 1;
      h = 0;
      guard = 0;
      payload = 0;
      while (h < last && guard < PoolMax) begin
        n = link_to[h];
        if (!in_use[h] && n > h) begin
          pay = n - h - 1;
          if (pay >= need) begin
            // exact fit takes the block whole
            if (pay > need) begin
              link_to[h + 1 + need] = n;
              in_use[h + 1 + need] = 1'b0;
              link_to[h] = h + 1 + need;
            end
            in_use[h] = 1'b1;
            payload = h + 1;
            return 1'b1;
          end
        end
        h = n;
        guard++;
      end
      return 1'b0;
    endfunction

    function bit on_chain(int unsigned target);
      int unsigned h, guard;
      h = 0;
      guard = 0;
      while (h < pool_len - 1 && guard < PoolMax) begin
        if (h == target) return 1'b1;
        h = link_to[h];
        guard++;
      end
      return 1'b0;
    endfunction

    function void coalesce(int unsigned h);
      int unsigned n, last, guard;
      last = pool_len - 1;
      guard = 0;
      while (h < last && guard < 2 * PoolMax) begin
        n = link_to[h];
        if (!in_use[h] && n < last && !in_use[n]) link_to[h] = link_to[n];
        else h = n;
        guard++;
      end
    endfunction

    function int unsigned percent_used();
      int unsigned h, n, pay, total, busy_words, guard;
      h = 0;
      total = 0;
      busy_words = 0;
      guard = 0;
      while (h < pool_len - 1 && guard < PoolMax) begin
        n = link_to[h];
        pay = (n > h) ? n - h - 1 : 0;
        total += pay;
        if (in_use[h]) busy_words += pay;
        h = n;
        guard++;
      end
      if (total == 0) return 0;
      return (100 * busy_words) / total;
    endfunction

    function void note_item(logic [fwpa_pkg::CmdW-1:0] cmd, logic [fwpa_pkg::ReqW-1:0] bytes,
                            logic [fwpa_pkg::IdxW-1:0] bidx);
      pool_answer_t a;
      int unsigned payload;
      a = '0;
      if (cmd == fwpa_pkg::CmdInit) begin
        rebuild();
        pool_built = 1'b1;
      end else if (!pool_built) begin
        a.status = fwpa_pkg::StatBad;
      end else if (cmd == fwpa_pkg::CmdAlloc) begin
        if (bytes == 0) a.status = fwpa_pkg::StatBad;
        else if (first_fit(bytes, payload)) begin
          a.status = fwpa_pkg::StatOk;
          a.payload_index = payload[fwpa_pkg::IdxW-1:0];
          live_blocks.push_back(payload);
        end else a.status = fwpa_pkg::StatNoFit;
      end else if (cmd == fwpa_pkg::CmdFree) begin
        if (bidx == 0 || !on_chain(bidx - 1)) begin
          a.status = fwpa_pkg::StatBad;
        end else begin
          in_use[bidx - 1] = 1'b0;
          coalesce(bidx - 1);
          foreach (live_blocks[i])
            if (live_blocks[i] == bidx) begin
              live_blocks.delete(i);
              break;
            end
        end
      end else begin
        a.usage_percent = percent_used();
      end
      answers.push_back(a);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_answer(logic [fwpa_pkg::StatW-1:0] st, logic [fwpa_pkg::IdxW-1:0] pidx,
                      logic [fwpa_pkg::PctW-1:0] pct);
      pool_answer_t a;
      if (answers.size() == 0) begin
        report($sformatf("unexpected result status %0d", st));
      end else begin
        a = answers.pop_front();
        if (st !== a.status)
          report($sformatf("status %0d, want %0d", st, a.status));
        if (pidx !== a.payload_index)
          report($sformatf("payload index %0d, want %0d", pidx, a.payload_index));
        if (pct !== a.usage_percent)
          report($sformatf("usage %0d, want %0d", pct, a.usage_percent));
      end
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [fwpa_pkg::CmdW-1:0]  command_i;
  logic [fwpa_pkg::ReqW-1:0]  request_bytes_i;
  logic [fwpa_pkg::IdxW-1:0]  block_index_i;
  logic                       cfg_we_i;
  logic [fwpa_pkg::CfgW-1:0]  pool_size_words_i;
  logic                       done_o;
  logic [fwpa_pkg::StatW-1:0] status_o;
  logic [fwpa_pkg::IdxW-1:0]  payload_index_o;
  logic [fwpa_pkg::PctW-1:0]  usage_percent_o;

  pool_scoreboard sb;
  int unsigned idle_pct;
  int unsigned stall_count;

  first_fit_word_pool_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .request_bytes_i  (request_bytes_i),
    .block_index_i    (block_index_i),
    .cfg_we_i         (cfg_we_i),
    .pool_size_words_i(pool_size_words_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .payload_index_o  (payload_index_o),
    .usage_percent_o  (usage_percent_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_answer(status_o, payload_index_o, usage_percent_o);
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_count <= 0;
    end else if (stall_count >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  task send_item(logic [fwpa_pkg::CmdW-1:0] cmd, logic [fwpa_pkg::ReqW-1:0] bytes,
                 logic [fwpa_pkg::IdxW-1:0] bidx);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    command_i <= cmd;
    request_bytes_i <= bytes;
    block_index_i <= bidx;
    do @(posedge clk_i); while (busy);
    sb.note_item(cmd, bytes, bidx);
  endtask

  task drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.answers.size() != 0 || busy) @(posedge clk_i);
  endtask

  task write_size(logic [fwpa_pkg::CfgW-1:0] words);
    drain();
    cfg_we_i <= 1'b1;
    pool_size_words_i <= words;
    @(posedge clk_i);
    sb.size_reg = words;
    cfg_we_i <= 1'b0;
  endtask

  task random_item();
    int unsigned sel, top;
    logic [fwpa_pkg::IdxW-1:0] bidx;
    sel = $urandom_range(99);
    top = (sb.pool_len * 4) / 6;
    if (top < 4) top = 4;
    if (top > 4095) top = 4095;
    if (sel < 45) begin
      if ($urandom_range(9) == 0)
        send_item(fwpa_pkg::CmdAlloc, 12'($urandom_range(4095)), '0);
      else
        send_item(fwpa_pkg::CmdAlloc, 12'($urandom_range(top, 1)), 10'($urandom_range(1023)));
    end else if (sel < 80) begin
      if (sb.live_blocks.size() != 0 && $urandom_range(9) < 8)
        bidx = 10'(sb.live_blocks[$urandom_range(sb.live_blocks.size() - 1)]);
      else
        bidx = 10'($urandom_range(1023));
      send_item(fwpa_pkg::CmdFree, 12'($urandom_range(4095)), bidx);
    end else if (sel < 90) begin
      send_item(fwpa_pkg::CmdUsage, 12'($urandom_range(4095)), 10'($urandom_range(1023)));
    end else if (sel < 93) begin
      send_item(fwpa_pkg::CmdInit, 12'($urandom_range(4095)), 10'($urandom_range(1023)));
    end else begin
      send_item(2'($urandom_range(3)), 12'($urandom_range(4095)), 10'($urandom_range(1023)));
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = fwpa_pkg::CmdInit;
    request_bytes_i = '0;
    block_index_i = '0;
    cfg_we_i = 1'b0;
    pool_size_words_i = fwpa_pkg::CfgRst;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // commands before the first init are refused
    send_item(fwpa_pkg::CmdAlloc, 12'd4, '0);
    send_item(fwpa_pkg::CmdFree, '0, 10'd1);
    send_item(fwpa_pkg::CmdUsage, '0, '0);

    // below-minimum size clamps to a one-word payload
    write_size(11'd0);
    send_item(fwpa_pkg::CmdInit, '0, '0);
    send_item(fwpa_pkg::CmdAlloc, '0, '0);
    send_item(fwpa_pkg::CmdAlloc, 12'd4, '0);
    send_item(fwpa_pkg::CmdUsage, '0, '0);
    send_item(fwpa_pkg::CmdAlloc, 12'd1, '0);
    send_item(fwpa_pkg::CmdFree, '0, 10'd1);
    send_item(fwpa_pkg::CmdFree, '0, 10'd1);
    send_item(fwpa_pkg::CmdFree, '0, 10'd0);
    send_item(fwpa_pkg::CmdFree, '0, 10'd2);
    send_item(fwpa_pkg::CmdFree, '0, 10'd1023);
    send_item(fwpa_pkg::CmdUsage, '0, '0);

    write_size(11'd2047);
    send_item(fwpa_pkg::CmdInit, 12'hfff, 10'h3ff);
    send_item(fwpa_pkg::CmdAlloc, 12'd4095, '0);
    send_item(fwpa_pkg::CmdAlloc, 12'd4088, '0);
    send_item(fwpa_pkg::CmdUsage, '0, '0);
    send_item(fwpa_pkg::CmdFree, '0, 10'd1);
    send_item(fwpa_pkg::CmdAlloc, 12'd1, '0);
    send_item(fwpa_pkg::CmdAlloc, 12'd5, '0);
    send_item(fwpa_pkg::CmdFree, '0, 10'd4);
    send_item(fwpa_pkg::CmdUsage, '0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_size(11'd1024);
        1: write_size(11'($urandom_range(40, 3)));
        2: write_size(11'd1025);
        default: write_size(11'($urandom_range(120, 4)));
      endcase
      idle_pct = (ph == 1) ? 76 : (ph == 3) ? 14 : 0;
      send_item(fwpa_pkg::CmdInit, '0, '0);
      for (int i = 0; i < 140; i++) begin
        random_item();
        // hold off once per phase until the pipeline is empty
        if (i == 70) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.answers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
